FILE: rtl/rtt_log_quantizer_top_defines.svh
// Assertion macros shared by the RTT quantiser checker.
`ifndef RTT_LOG_QUANTIZER_TOP_DEFINES_SVH
`define RTT_LOG_QUANTIZER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled in reset
`define RTTQ_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled in reset
`define RTTQ_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/rttq_pkg.sv
// Types, constants and threshold ROM of the RTT log quantiser.
package rttq_pkg;

    localparam int RTT_W          = 32;
    localparam int CODE_W         = 8;
    localparam int T_W            = 30;
    localparam int ROM_DEPTH      = 256;
    localparam int LOG_FIRST_CODE = 32;
    localparam int FRAC_BITS      = 34;
    localparam int BITS_PER_STAGE = 2;
    // one clamp stage plus four search stages of two bits each
    localparam int NUM_STAGES     = 5;

    typedef logic [RTT_W-1:0]  rtt_us_t;
    typedef logic [CODE_W-1:0] rtt_code_t;
    typedef logic [T_W-1:0]    thr_t;
    typedef thr_t              thr_rom_t [ROM_DEPTH];

    localparam thr_t      RTT_MIN_US   = 30'd1;
    localparam thr_t      RTT_MAX_US   = 30'd1000000000;
    localparam thr_t      LIN_LIMIT_US = 30'd33;
    localparam rtt_code_t CODE_LAST    = 8'd255;

    // exp(-1/13) in Q1.63, Horner form of the series, 16 terms
    localparam logic [63:0] EXP_ONE = 64'h8000_0000_0000_0000;
    localparam logic [63:0] H16 = EXP_ONE - EXP_ONE / 64'd208;
    localparam logic [63:0] H15 = EXP_ONE - H16 / 64'd195;
    localparam logic [63:0] H14 = EXP_ONE - H15 / 64'd182;
    localparam logic [63:0] H13 = EXP_ONE - H14 / 64'd169;
    localparam logic [63:0] H12 = EXP_ONE - H13 / 64'd156;
    localparam logic [63:0] H11 = EXP_ONE - H12 / 64'd143;
    localparam logic [63:0] H10 = EXP_ONE - H11 / 64'd130;
    localparam logic [63:0] H9  = EXP_ONE - H10 / 64'd117;
    localparam logic [63:0] H8  = EXP_ONE - H9 / 64'd104;
    localparam logic [63:0] H7  = EXP_ONE - H8 / 64'd91;
    localparam logic [63:0] H6  = EXP_ONE - H7 / 64'd78;
    localparam logic [63:0] H5  = EXP_ONE - H6 / 64'd65;
    localparam logic [63:0] H4  = EXP_ONE - H5 / 64'd52;
    localparam logic [63:0] H3  = EXP_ONE - H4 / 64'd39;
    localparam logic [63:0] H2  = EXP_ONE - H3 / 64'd26;
    localparam logic [63:0] EXP_STEP = EXP_ONE - H2 / 64'd13;

    // (a * b) >> 63 with round to nearest; elaboration only
    function automatic logic [63:0] mul_q63(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        prod = prod + (128'd1 << 62);
        return prod[126:63];
    endfunction

    // Thresholds floor(1e9 * exp((q-255)/13)) for q = 32..255, zero below
    function automatic thr_rom_t build_thr_rom();
        thr_rom_t    rom;
        logic [63:0] v;
        logic [63:0] sh;
        for (int i = 0; i < ROM_DEPTH; i++)
        begin
            rom[i] = '0;
        end
        v = {34'd0, RTT_MAX_US} << FRAC_BITS;
        for (int k = 0; k <= ROM_DEPTH - 1 - LOG_FIRST_CODE; k++)
        begin
            sh = v >> FRAC_BITS;
            rom[ROM_DEPTH - 1 - k] = sh[T_W-1:0];
            v = mul_q63(v, EXP_STEP);
        end
        return rom;
    endfunction

    localparam thr_rom_t THR_ROM = build_thr_rom();

endpackage

FILE: rtl/rttq_in_if.sv
// Input channel: one round-trip time sample per transaction.
interface rttq_in_if;
    logic             valid;
    logic             ready;
    rttq_pkg::rtt_us_t rtt_us;

    modport source (output valid, output rtt_us, input ready);
    modport sink   (input valid, input rtt_us, output ready);
endinterface

FILE: rtl/rttq_out_if.sv
// Output channel: one quantised code per transaction.
interface rttq_out_if;
    logic               valid;
    logic               ready;
    rttq_pkg::rtt_code_t rtt_code;

    modport source (output valid, output rtt_code, input ready);
    modport sink   (input valid, input rtt_code, output ready);
endinterface

FILE: rtl/rtt_log_quantizer_top.sv
// RTT log quantiser: clamp stage and four-stage binary search over the threshold ROM.
//
//   channel     dir   payload            handshake
//   sample_ch   in    rtt_us   [31:0]    valid / ready
//   code_ch     out   rtt_code [7:0]     valid / ready
//
// One transaction per cycle sustained while code_ch.ready stays high; there is one clamp stage
// and four search stages each resolving two code bits against the ROM.
// rst_n clears the stage valid bits asynchronously; data registers are not reset.
// Each stage holds while the one after it is full and stalled; empty stages
// still fill, so bubbles close up under back-pressure.
module rtt_log_quantizer_top (
    input  logic       clk,
    input  logic       rst_n,
    rttq_in_if.sink    sample_ch,
    rttq_out_if.source code_ch
);

    localparam int LAST = rttq_pkg::NUM_STAGES - 1;

    // Stage registers; stages 0..LAST-1 carry the search state
    logic                valid_reg [rttq_pkg::NUM_STAGES];
    rttq_pkg::thr_t      t_reg     [LAST];
    logic                lin_reg   [LAST];
    rttq_pkg::rtt_code_t p_reg     [LAST];
    rttq_pkg::rtt_code_t code_reg;
    logic                stage_ready [rttq_pkg::NUM_STAGES];

    // Resolve two code bits: keep the largest p whose threshold is below t
    function automatic rttq_pkg::rtt_code_t refine(input rttq_pkg::thr_t t,
                                                   input rttq_pkg::rtt_code_t p,
                                                   input int msb);
        rttq_pkg::rtt_code_t cur;
        rttq_pkg::rtt_code_t cand;
        cur = p;
        for (int i = 0; i < rttq_pkg::BITS_PER_STAGE; i++)
        begin
            cand = cur | (rttq_pkg::rtt_code_t'(1) << (msb - i));
            if (rttq_pkg::THR_ROM[cand] < t)
            begin
                cur = cand;
            end
        end
        return cur;
    endfunction

    // Ready chain: a stage takes new data when empty or when it moves on
    assign stage_ready[LAST] = !valid_reg[LAST] || code_ch.ready;
    for (genvar s = 0; s < LAST; s++)
    begin : g_ready
        assign stage_ready[s] = !valid_reg[s] || stage_ready[s+1];
    end

    assign sample_ch.ready  = stage_ready[0];
    assign code_ch.valid    = valid_reg[LAST];
    assign code_ch.rtt_code = code_reg;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < rttq_pkg::NUM_STAGES; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else
        begin
            if (stage_ready[0])
            begin
                valid_reg[0] <= sample_ch.valid;
            end
            for (int s = 1; s < rttq_pkg::NUM_STAGES; s++)
            begin
                if (stage_ready[s])
                begin
                    valid_reg[s] <= valid_reg[s-1];
                end
            end
        end
    end

    // Stage 0: clamp to 1..1e9 us and settle the linear range
    rttq_pkg::thr_t      t_clamp_next;
    logic                lin_next;
    rttq_pkg::rtt_code_t p0_next;

    always_comb
    begin
        if (sample_ch.rtt_us == '0)
        begin
            t_clamp_next = rttq_pkg::RTT_MIN_US;
        end
        else if (sample_ch.rtt_us > rttq_pkg::rtt_us_t'(rttq_pkg::RTT_MAX_US))
        begin
            t_clamp_next = rttq_pkg::RTT_MAX_US;
        end
        else
        begin
            t_clamp_next = sample_ch.rtt_us[rttq_pkg::T_W-1:0];
        end
        lin_next = (t_clamp_next < rttq_pkg::LIN_LIMIT_US);
        p0_next  = lin_next ? (t_clamp_next[rttq_pkg::CODE_W-1:0] - 8'd1) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[0] && sample_ch.valid)
        begin
            t_reg[0]   <= t_clamp_next;
            lin_reg[0] <= lin_next;
            p_reg[0]   <= p0_next;
        end
    end

    // Search stages 1..LAST-1
    for (genvar s = 1; s < LAST; s++)
    begin : g_search
        localparam int MSB = rttq_pkg::CODE_W - 1 - rttq_pkg::BITS_PER_STAGE * (s - 1);
        rttq_pkg::rtt_code_t p_next;

        assign p_next = lin_reg[s-1] ? p_reg[s-1] : refine(t_reg[s-1], p_reg[s-1], MSB);

        always_ff @(posedge clk)
        begin
            if (stage_ready[s] && valid_reg[s-1])
            begin
                t_reg[s]   <= t_reg[s-1];
                lin_reg[s] <= lin_reg[s-1];
                p_reg[s]   <= p_next;
            end
        end
    end

    // Last stage: final two bits, then the code is the first threshold not below t (linear range: p as is)
    rttq_pkg::rtt_code_t p_last;
    rttq_pkg::rtt_code_t code_next;

    always_comb
    begin
        p_last    = refine(t_reg[LAST-1], p_reg[LAST-1], rttq_pkg::BITS_PER_STAGE - 1);
        code_next = lin_reg[LAST-1] ? p_reg[LAST-1] : (p_last + 8'd1);
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[LAST] && valid_reg[LAST-1])
        begin
            code_reg <= code_next;
        end
    end

endmodule

FILE: rtl/rttq_checker.sv
// Port-level checker for the RTT log quantiser, bound to the top level.
`include "rtt_log_quantizer_top_defines.svh"

module rttq_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input rttq_pkg::rtt_code_t out_code
);

    // Transactions accepted but not yet delivered
    logic [3:0] pending_reg;
    logic [3:0] pending_next;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_valid && in_ready)
        begin
            pending_next = pending_next + 4'd1;
        end
        if (out_valid && out_ready)
        begin
            pending_next = pending_next - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `RTTQ_ASSERT_IMP(a_no_invented, out_valid, pending_reg != 4'd0, "result with nothing pending")
    `RTTQ_ASSERT_IMP(a_depth, 1'b1, pending_reg <= 4'(rttq_pkg::NUM_STAGES), "more pending than stages")
    `RTTQ_ASSERT_IMP(a_empty_ready, pending_reg == 4'd0, in_ready, "empty pipeline not ready")
    `RTTQ_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_code), "stalled result changed")

endmodule

bind rtt_log_quantizer_top rttq_checker u_rttq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample_ch.valid),
    .in_ready  (sample_ch.ready),
    .out_valid (code_ch.valid),
    .out_ready (code_ch.ready),
    .out_code  (code_ch.rtt_code)
);
